// ===== hw/rtl/piecewise_linear_table_interp_top_macros.svh =====
// Assertion macros for the piecewise-linear table interpolator.
// Included by the RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define PLTI_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PLTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PLTI_ASSERT(lbl, ante, cons, msg)
`define PLTI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/plti_pkg.sv =====
// Package for the piecewise-linear table interpolator: widths, codes, stage map, types.
// No dependencies.
package plti_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int PTIDX_W    = 6;
  localparam int POS_W      = 16;
  localparam int VAL_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int CNT_W      = 6;
  localparam int GAIN_FRAC  = 12;
  localparam int PROD_W     = VAL_W + POS_W;
  localparam int GPROD_W    = VAL_W + GAIN_W;
  localparam int SCALED_W   = GPROD_W - GAIN_FRAC;

  localparam logic [CNT_W-1:0]  SEG_CNT_RESET = CNT_W'(28);
  localparam logic [GAIN_W-1:0] GAIN_RESET    = GAIN_W'(1331);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // segment search: hit vector split in groups of GROUP_W
  localparam int GROUP_W     = 8;
  localparam int GROUP_COUNT = (MAX_POINTS + GROUP_W - 1) / GROUP_W;
  localparam int LGRP_W      = $clog2(GROUP_W);

  // long division, quotient bits per stage
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = VAL_W / DIV_BITS_PER_STAGE;

  // pipeline stage numbers
  localparam int STG_CMP     = 1;
  localparam int STG_GRP     = 2;
  localparam int STG_SEG     = 3;
  localparam int STG_MEM     = 4;
  localparam int STG_DIFF    = 5;
  localparam int STG_MUL     = 6;
  localparam int STG_DIV0    = 7;
  localparam int STG_INTERP  = STG_DIV0 + DIV_STAGES;
  localparam int STG_GAIN    = STG_INTERP + 1;
  localparam int STG_OUT     = STG_GAIN + 1;
  localparam int STAGE_COUNT = STG_OUT;

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEGMENT_COUNT = 1'b0,
    REG_OUTPUT_GAIN   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] level;
  } point_t;

  typedef struct packed {
    logic [POS_W-1:0] rem;
    logic [VAL_W-1:0] sh;   // dividend bits shift out on top, quotient bits in at bottom
  } div_t;

  typedef struct packed {
    logic             rng;
    logic             fnd;
    logic             neg;
    logic [VAL_W-1:0] y0;
    logic [POS_W-1:0] span;
    div_t             dv;
  } div_stage_t;

endpackage

// ===== hw/rtl/piecewise_linear_table_interp_top.sv =====
// Piecewise-linear lookup table with output gain, fully pipelined.
// Depends on plti_pkg and piecewise_linear_table_interp_top_macros.svh.
//
// One item enters per clock when nothing stalls; the pipeline holds a six-stage long
// divider (four quotient bits per stage) between the interpolation multiply and the
// gain multiply. Stalls hold a stage only while the stage after it is full, so bubbles
// close up. Breakpoint positions live in flops for the parallel segment compare and,
// together with the levels, in two RAM copies read at the segment and at the segment
// plus one. A write item updates the compare flops as it enters and the RAMs three
// stages later, so every evaluate sees exactly the writes that came before it. Write
// items give no result; every evaluate gives one. Breakpoint storage has no reset: the
// user must read only slots written before use; the block does not enforce this.
`include "piecewise_linear_table_interp_top_macros.svh"

module piecewise_linear_table_interp_top
  import plti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic [PTIDX_W-1:0]    point_index,
  input  logic [POS_W-1:0]      position,
  input  logic [VAL_W-1:0]      point_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VAL_W-1:0]      result_value,
  output logic                  in_range,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [CNT_W-1:0]  segment_count;
  logic [GAIN_W-1:0] output_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= SEG_CNT_RESET;
      output_gain   <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEGMENT_COUNT: segment_count <= cfg_data[CNT_W-1:0];
        REG_OUTPUT_GAIN:   output_gain   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage control
  logic [STAGE_COUNT:1]   vld;
  logic [STAGE_COUNT+1:1] load;

  always_comb begin
    load[STAGE_COUNT+1] = !out_stall;
    for (int k = STAGE_COUNT; k >= 1; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign in_stall  = !load[STG_CMP];
  assign out_valid = vld[STG_OUT];

  // stage 1: parallel compare against every breakpoint position
  logic [POS_W-1:0]      pos_tab [MAX_POINTS];
  logic [MAX_POINTS-1:0] ge;
  logic [IDX_W-1:0]      n_eff;

  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      ge[i] = position >= pos_tab[i];
    end
    if (int'(segment_count) > MAX_POINTS - 1) begin
      n_eff = IDX_W'(MAX_POINTS - 1);
    end else begin
      n_eff = IDX_W'(segment_count);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && load[STG_CMP] && operation == OP_WRITE &&
        int'(point_index) < MAX_POINTS) begin
      pos_tab[point_index[IDX_W-1:0]] <= position;
    end
  end

  logic                  s1_op;
  logic [PTIDX_W-1:0]    s1_slot;
  logic [POS_W-1:0]      s1_pos;
  logic [VAL_W-1:0]      s1_val;
  logic [MAX_POINTS-1:0] s1_ge;
  logic [IDX_W-1:0]      s1_n;

  always_ff @(posedge clk) begin
    if (load[STG_CMP]) begin
      s1_op   <= operation;
      s1_slot <= point_index;
      s1_pos  <= position;
      s1_val  <= point_value;
      s1_ge   <= ge;
      s1_n    <= n_eff;
    end
  end

  // stage 2: segment hits, first hit inside each group
  logic [GROUP_COUNT*GROUP_W-1:0] hit;
  logic                           rng2;
  logic [GROUP_COUNT-1:0]         gany;
  logic [LGRP_W-1:0]              gidx [GROUP_COUNT];

  always_comb begin
    hit = '0;
    for (int i = 0; i < MAX_POINTS - 1; i++) begin
      hit[i] = s1_ge[i] && !s1_ge[i+1] && (i < int'(s1_n));
    end
    rng2 = (s1_n != '0) && s1_ge[0] && !s1_ge[s1_n];
    for (int g = 0; g < GROUP_COUNT; g++) begin
      gany[g] = |hit[g*GROUP_W +: GROUP_W];
      gidx[g] = '0;
      for (int j = GROUP_W - 1; j >= 0; j--) begin
        if (hit[g*GROUP_W + j]) begin
          gidx[g] = LGRP_W'(j);
        end
      end
    end
  end

  logic                   s2_op;
  logic [PTIDX_W-1:0]     s2_slot;
  logic [POS_W-1:0]       s2_pos;
  logic [VAL_W-1:0]       s2_val;
  logic                   s2_rng;
  logic [GROUP_COUNT-1:0] s2_gany;
  logic [LGRP_W-1:0]      s2_gidx [GROUP_COUNT];

  always_ff @(posedge clk) begin
    if (load[STG_GRP]) begin
      s2_op   <= s1_op;
      s2_slot <= s1_slot;
      s2_pos  <= s1_pos;
      s2_val  <= s1_val;
      s2_rng  <= rng2;
      s2_gany <= gany;
      s2_gidx <= gidx;
    end
  end

  // stage 3: pick the first group with a hit
  logic [IDX_W-1:0] seg3;

  always_comb begin
    seg3 = '0;
    for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
      if (s2_gany[g]) begin
        seg3 = IDX_W'(g * GROUP_W) + IDX_W'(s2_gidx[g]);
      end
    end
  end

  logic               s3_op;
  logic [PTIDX_W-1:0] s3_slot;
  logic [POS_W-1:0]   s3_pos;
  logic [VAL_W-1:0]   s3_val;
  logic               s3_rng;
  logic               s3_fnd;
  logic [IDX_W-1:0]   s3_seg;

  always_ff @(posedge clk) begin
    if (load[STG_SEG]) begin
      s3_op   <= s2_op;
      s3_slot <= s2_slot;
      s3_pos  <= s2_pos;
      s3_val  <= s2_val;
      s3_rng  <= s2_rng;
      s3_fnd  <= |s2_gany;
      s3_seg  <= seg3;
    end
  end

  // stage 4: breakpoint RAMs, one copy per read port
  point_t           mem_lo [MAX_POINTS];
  point_t           mem_hi [MAX_POINTS];
  point_t           rd_lo;
  point_t           rd_hi;
  logic [IDX_W-1:0] seg_up;
  logic             mem_we;

  assign seg_up = s3_seg + IDX_W'(1);
  assign mem_we = vld[STG_SEG] && s3_op == OP_WRITE && int'(s3_slot) < MAX_POINTS;

  always_ff @(posedge clk) begin
    if (load[STG_MEM]) begin
      if (mem_we) begin
        mem_lo[s3_slot[IDX_W-1:0]] <= '{pos: s3_pos, level: s3_val};
        mem_hi[s3_slot[IDX_W-1:0]] <= '{pos: s3_pos, level: s3_val};
      end
      rd_lo <= mem_lo[s3_seg];
      rd_hi <= mem_hi[seg_up];
    end
  end

  logic             s4_rng;
  logic             s4_fnd;
  logic [POS_W-1:0] s4_pos;

  always_ff @(posedge clk) begin
    if (load[STG_MEM]) begin
      s4_rng <= s3_rng;
      s4_fnd <= s3_fnd;
      s4_pos <= s3_pos;
    end
  end

  // stage 5: differences
  logic             s5_rng;
  logic             s5_fnd;
  logic             s5_neg;
  logic [VAL_W-1:0] s5_y0;
  logic [VAL_W-1:0] s5_dmag;
  logic [POS_W-1:0] s5_off;
  logic [POS_W-1:0] s5_span;
  logic             neg5;

  assign neg5 = rd_hi.level < rd_lo.level;

  always_ff @(posedge clk) begin
    if (load[STG_DIFF]) begin
      s5_rng  <= s4_rng;
      s5_fnd  <= s4_fnd;
      s5_neg  <= neg5;
      s5_y0   <= rd_lo.level;
      s5_dmag <= neg5 ? rd_lo.level - rd_hi.level : rd_hi.level - rd_lo.level;
      s5_off  <= s4_pos - rd_lo.pos;
      s5_span <= rd_hi.pos - rd_lo.pos;
    end
  end

  // stage 6: |delta| * offset
  logic              s6_rng;
  logic              s6_fnd;
  logic              s6_neg;
  logic [VAL_W-1:0]  s6_y0;
  logic [POS_W-1:0]  s6_span;
  logic [PROD_W-1:0] s6_prod;

  always_ff @(posedge clk) begin
    if (load[STG_MUL]) begin
      s6_rng  <= s5_rng;
      s6_fnd  <= s5_fnd;
      s6_neg  <= s5_neg;
      s6_y0   <= s5_y0;
      s6_span <= s5_span;
      s6_prod <= PROD_W'(s5_dmag) * PROD_W'(s5_off);
    end
  end

  // stages 7..12: restoring division by span; offset < span keeps the quotient in VAL_W
  function automatic div_t div_steps(input div_t cur, input logic [POS_W-1:0] span);
    div_t         acc;
    logic [POS_W:0] trial;
    acc = cur;
    for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
      trial  = {acc.rem, acc.sh[VAL_W-1]};
      acc.sh = {acc.sh[VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, span}) begin
        trial     = trial - {1'b0, span};
        acc.sh[0] = 1'b1;
      end
      acc.rem = trial[POS_W-1:0];
    end
    return acc;
  endfunction

  div_stage_t d_src  [DIV_STAGES];
  div_stage_t d_next [DIV_STAGES];
  div_stage_t d_q    [DIV_STAGES];

  always_comb begin
    d_src[0].rng = s6_rng;
    d_src[0].fnd = s6_fnd;
    d_src[0].neg = s6_neg;
    d_src[0].y0  = s6_y0;
    d_src[0].span = s6_span;
    d_src[0].dv  = '{rem: s6_prod[PROD_W-1:VAL_W], sh: s6_prod[VAL_W-1:0]};
    for (int j = 1; j < DIV_STAGES; j++) begin
      d_src[j] = d_q[j-1];
    end
    for (int j = 0; j < DIV_STAGES; j++) begin
      d_next[j]    = d_src[j];
      d_next[j].dv = div_steps(d_src[j].dv, d_src[j].span);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (load[STG_DIV0 + j]) begin
        d_q[j] <= d_next[j];
      end
    end
  end

  // stage 13: apply the correction to the left level
  div_stage_t       d_last;
  logic             s13_rng;
  logic             s13_fnd;
  logic [VAL_W-1:0] s13_y;

  assign d_last = d_q[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (load[STG_INTERP]) begin
      s13_rng <= d_last.rng;
      s13_fnd <= d_last.fnd;
      s13_y   <= d_last.neg ? d_last.y0 - d_last.dv.sh : d_last.y0 + d_last.dv.sh;
    end
  end

  // stage 14: gain
  logic               s14_rng;
  logic               s14_fnd;
  logic [GPROD_W-1:0] s14_prod;

  always_ff @(posedge clk) begin
    if (load[STG_GAIN]) begin
      s14_rng  <= s13_rng;
      s14_fnd  <= s13_fnd;
      s14_prod <= GPROD_W'(s13_y) * GPROD_W'(output_gain);
    end
  end

  // stage 15: scale back, saturate, output register
  logic [SCALED_W-1:0] scaled;
  logic [VAL_W-1:0]    sat;

  assign scaled = s14_prod[GPROD_W-1:GAIN_FRAC];
  assign sat    = (|scaled[SCALED_W-1:VAL_W]) ? '1 : scaled[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (load[STG_OUT]) begin
      result_value <= (s14_rng && s14_fnd) ? sat : '0;
      in_range     <= s14_rng;
    end
  end

  // valid bits; write items drop out once the RAMs are updated
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= STAGE_COUNT; k++) begin
        if (load[k]) begin
          if (k == STG_CMP) begin
            vld[k] <= in_valid;
          end else if (k == STG_MEM) begin
            vld[k] <= vld[k-1] && s3_op == OP_EVAL;
          end else begin
            vld[k] <= vld[k-1];
          end
        end
      end
    end
  end

  `PLTI_ASSERT(a_offset_in_span, vld[STG_DIFF] && s5_rng && s5_fnd, s5_off < s5_span, "query outside selected segment")
  `PLTI_ASSERT(a_div_first_rem, vld[STG_DIV0] && d_q[0].rng && d_q[0].fnd, d_q[0].dv.rem < d_q[0].span, "divider remainder out of bound")
  `PLTI_ASSERT(a_div_last_rem, vld[STG_INTERP-1] && d_last.rng && d_last.fnd, d_last.dv.rem < d_last.span, "divider remainder out of bound at last stage")
  `PLTI_ASSERT(a_zero_out_of_span, out_valid && !in_range, result_value == '0, "nonzero result outside table span")
  `PLTI_ASSERT_NEXT(a_gain_to_out, vld[STG_GAIN] && load[STG_OUT], out_valid, "result lost between gain and output stage")

endmodule

// ===== dv/plti_lookup_checker.sv =====
// Checker for the piecewise-linear table interpolator: watches the input, output and
// register ports, predicts every lookup result and compares it field by field.
// Depends on plti_pkg.
module plti_lookup_checker
  import plti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  operation,
  input  logic [PTIDX_W-1:0]    point_index,
  input  logic [POS_W-1:0]      position,
  input  logic [VAL_W-1:0]      point_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [VAL_W-1:0]      result_value,
  input  logic                  in_range,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    lookups_seen,
  output int                    in_span_seen,
  output int                    ceiling_seen,
  output int                    writes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [VAL_W-1:0] VALUE_CAP = '1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             in_span;
  } lookup_t;

  logic [POS_W-1:0]  bp_pos   [MAX_POINTS];
  logic [VAL_W-1:0]  bp_level [MAX_POINTS];
  logic [CNT_W-1:0]  seg_count_q = SEG_CNT_RESET;
  logic [GAIN_W-1:0] gain_q      = GAIN_RESET;
  lookup_t           expected_lookups [$];

  int n_mismatch = 0;
  int n_lookup   = 0;
  int n_in_span  = 0;
  int n_ceiling  = 0;
  int n_write    = 0;
  int n_pending  = 0;

  assign mismatches   = n_mismatch;
  assign outstanding  = n_pending;
  assign lookups_seen = n_lookup;
  assign in_span_seen = n_in_span;
  assign ceiling_seen = n_ceiling;
  assign writes_seen  = n_write;

  // Linear blend inside one segment; the correction is truncated in magnitude.
  function automatic logic [VAL_W-1:0] blend_level(int seg, logic [POS_W-1:0] q);
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] off;
    logic [PROD_W-1:0] mag;
    span = bp_pos[seg+1] - bp_pos[seg];
    off  = q - bp_pos[seg];
    if (span == '0) return bp_level[seg];
    if (bp_level[seg+1] >= bp_level[seg]) begin
      mag = (PROD_W'(bp_level[seg+1] - bp_level[seg]) * PROD_W'(off)) / PROD_W'(span);
      return bp_level[seg] + mag[VAL_W-1:0];
    end
    mag = (PROD_W'(bp_level[seg] - bp_level[seg+1]) * PROD_W'(off)) / PROD_W'(span);
    return bp_level[seg] - mag[VAL_W-1:0];
  endfunction

  function automatic lookup_t predict_lookup(logic [POS_W-1:0] q);
    lookup_t r;
    int n;
    logic [GPROD_W-1:0] prod;
    r = '0;
    n = int'(seg_count_q);
    if (n == 0) return r;
    if (q < bp_pos[0] || q >= bp_pos[n]) return r;
    r.in_span = 1'b1;
    // first segment that holds the query wins
    for (int i = 0; i < n; i++) begin
      if (q >= bp_pos[i] && q < bp_pos[i+1]) begin
        prod = (GPROD_W'(blend_level(i, q)) * GPROD_W'(gain_q)) >> GAIN_FRAC;
        r.value = (prod > GPROD_W'(VALUE_CAP)) ? VALUE_CAP : prod[VAL_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      seg_count_q = SEG_CNT_RESET;
      gain_q      = GAIN_RESET;
      expected_lookups.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          $error("result transfer with nothing expected: result_value %0h in_range %0b",
                 result_value, in_range);
          n_mismatch++;
        end else begin
          want = expected_lookups.pop_front();
          n_lookup++;
          if (want.in_span) n_in_span++;
          if (want.value == VALUE_CAP) n_ceiling++;
          if (result_value !== want.value) begin
            $error("result_value: expected %0h, got %0h", want.value, result_value);
            n_mismatch++;
          end
          if (in_range !== want.in_span) begin
            $error("in_range: expected %0b, got %0b", want.in_span, in_range);
            n_mismatch++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_SEGMENT_COUNT: seg_count_q = cfg_data[CNT_W-1:0];
          REG_OUTPUT_GAIN:   gain_q = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (operation == OP_WRITE) begin
          bp_pos[point_index]   = position;
          bp_level[point_index] = point_value;
          n_write++;
        end else begin
          expected_lookups.push_back(predict_lookup(position));
        end
      end
    end
    n_pending = expected_lookups.size();
  end

endmodule

// ===== dv/piecewise_linear_table_interp_top_tb.sv =====
// Testbench top for the piecewise-linear table interpolator: clock, reset, stimulus and
// verdict. Depends on plti_pkg, piecewise_linear_table_interp_top and plti_lookup_checker.
module piecewise_linear_table_interp_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plti_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 24;   // pipeline is 15 deep, writes give no result
  localparam int HOLD_CYCLES  = 200;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef enum {SHAPE_RAMP, SHAPE_EDGES, SHAPE_SCRAMBLED} shape_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  operation = 1'b0;
  logic [PTIDX_W-1:0]    point_index = '0;
  logic [POS_W-1:0]      position = '0;
  logic [VAL_W-1:0]      point_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VAL_W-1:0]      result_value;
  logic                  in_range;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int lookups_seen;
  int in_span_seen;
  int ceiling_seen;
  int writes_seen;

  // stimulus-side copy of the table, used only to aim queries
  logic [POS_W-1:0] tbl_pos   [MAX_POINTS];
  logic [VAL_W-1:0] tbl_level [MAX_POINTS];
  logic [CNT_W-1:0] active_segs = SEG_CNT_RESET;
  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int settings_run = 0;

  piecewise_linear_table_interp_top u_dut (.*);
  plti_lookup_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $error("run did not finish in time, %0d lookups still expected", outstanding);
    $display("CHECK FAILED");
    $finish;
  end

  // Output side: short random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(op_t op, logic [PTIDX_W-1:0] idx, logic [POS_W-1:0] pos,
                           logic [VAL_W-1:0] val);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    point_index <= idx;
    position    <= pos;
    point_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic put_point(int slot, logic [POS_W-1:0] pos, logic [VAL_W-1:0] lvl);
    tbl_pos[slot]   = pos;
    tbl_level[slot] = lvl;
    send_item(OP_WRITE, PTIDX_W'(slot), pos, lvl);
  endtask

  task automatic probe(logic [POS_W-1:0] q);
    send_item(OP_EVAL, '0, q, '0);
  endtask

  // Wait for every lookup to come back, then let trailing writes leave the pipe.
  // It waits for a clock edge first so the checker has logged the last transfer.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(logic [CNT_W-1:0] segs, logic [GAIN_W-1:0] gain);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[CNT_W-1:0] = segs;   // upper bits are don't-care for the count
    cfg_write <= 1'b1;
    cfg_index <= REG_SEGMENT_COUNT;
    cfg_data  <= word;
    @(posedge clk);
    cfg_index <= REG_OUTPUT_GAIN;
    cfg_data  <= gain;
    @(posedge clk);
    cfg_write <= 1'b0;
    active_segs = segs;
    settings_run++;
  endtask

  task automatic load_table(shape_t shape);
    int n;
    int step_max;
    int p;
    logic [VAL_W-1:0] lvl;
    n = int'(active_segs);
    step_max = 65535 / (n + 1);
    p = (shape == SHAPE_EDGES) ? 0 : $urandom_range(0, step_max);
    for (int s = 0; s <= n; s++) begin
      lvl = VAL_W'($urandom);
      if (shape == SHAPE_EDGES && $urandom_range(0, 1) == 1) lvl = s[0] ? '1 : '0;
      if (shape == SHAPE_SCRAMBLED) put_point(s, POS_W'($urandom), lvl);
      else if (shape == SHAPE_EDGES && s == n && n > 0) put_point(s, '1, lvl);
      else put_point(s, POS_W'(p), lvl);
      p += $urandom_range(1, step_max);
    end
  endtask

  task automatic send_lookup();
    int n;
    int s;
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    n  = int'(active_segs);
    s  = $urandom_range(0, n);
    lo = tbl_pos[s];
    hi = (s < n) ? tbl_pos[s+1] : tbl_pos[s];
    case ($urandom_range(0, 9))
      0: q = tbl_pos[s];
      1: q = (tbl_pos[0] > 0) ? POS_W'($urandom_range(0, tbl_pos[0] - 1)) : POS_W'($urandom);
      2: q = POS_W'($urandom_range(tbl_pos[n], 16'hFFFF));
      3: q = POS_W'($urandom);
      default: q = (hi > lo) ? POS_W'($urandom_range(lo, hi - 1)) : POS_W'($urandom);
    endcase
    send_item(OP_EVAL, PTIDX_W'($urandom), q, VAL_W'($urandom));
  endtask

  task automatic run_phase(shape_t shape, int items);
    int r;
    int s;
    int lo;
    int hi;
    load_table(shape);
    repeat (items) begin
      r = $urandom_range(0, 19);
      if (r == 0 && active_segs < MAX_POINTS - 1) begin
        put_point($urandom_range(active_segs + 1, MAX_POINTS - 1), POS_W'($urandom),
                  VAL_W'($urandom));
      end else if (r == 1) begin
        // move one breakpoint (between its neighbors unless scrambled) while lookups are in flight
        s  = $urandom_range(0, active_segs);
        lo = (s == 0) ? 0 : int'(tbl_pos[s-1]) + 1;
        hi = (s == active_segs) ? 65535 : int'(tbl_pos[s+1]) - 1;
        if (shape == SHAPE_SCRAMBLED) put_point(s, POS_W'($urandom), VAL_W'($urandom));
        else if (hi >= lo) put_point(s, POS_W'($urandom_range(lo, hi)), VAL_W'($urandom));
        else send_lookup();
      end else begin
        send_lookup();
      end
    end
    drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: span ends, rising and falling segments, exact breakpoints
    set_registers(CNT_W'(4), 16'h1000);
    put_point(0, 16'd0, 24'h000000);
    put_point(1, 16'd100, 24'hFFFFFF);
    put_point(2, 16'd200, 24'h000000);
    put_point(3, 16'd300, 24'h800000);
    put_point(4, 16'hFFFF, 24'h123456);
    probe(16'd0);
    probe(16'd50);
    probe(16'd99);
    probe(16'd100);
    probe(16'd150);
    probe(16'd250);
    probe(16'd300);
    probe(16'hFFFE);
    probe(16'hFFFF);
    drain();
    // empty span
    set_registers(CNT_W'(0), 16'h1000);
    probe(16'd0);
    probe(16'd150);
    drain();
    // full gain, one segment: saturation and the upper edge
    set_registers(CNT_W'(1), 16'hFFFF);
    probe(16'd50);
    probe(16'd99);
    probe(16'd100);
    drain();

    set_registers(CNT_W'(28), GAIN_RESET);
    run_phase(SHAPE_RAMP, 120);
    set_registers(CNT_W'(63), 16'h1000);
    run_phase(SHAPE_EDGES, 150);
    set_registers(CNT_W'(1), 16'hFFFF);
    run_phase(SHAPE_EDGES, 80);
    set_registers(CNT_W'(7), 16'h0000);
    run_phase(SHAPE_RAMP, 80);
    hold_req = 1'b1;
    set_registers(CNT_W'(63), 16'hFFFF);
    run_phase(SHAPE_SCRAMBLED, 160);
    set_registers(CNT_W'($urandom_range(1, 63)), GAIN_W'($urandom));
    run_phase(SHAPE_RAMP, 160);
    set_registers(CNT_W'(0), GAIN_W'($urandom));
    run_phase(SHAPE_RAMP, 40);
    set_registers(CNT_W'($urandom_range(2, 63)), GAIN_W'($urandom));
    run_phase(SHAPE_SCRAMBLED, 120);
    quiet = 1'b1;
    set_registers(CNT_W'(15), 16'h2000);
    run_phase(SHAPE_RAMP, 250);

    $display("Checked %0d lookups (%0d inside the table span, %0d clipped at full scale)",
             lookups_seen, in_span_seen, ceiling_seen);
    $display("with %0d breakpoint writes over %0d register settings.",
             writes_seen, settings_run);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/plti_pkg.sv
hw/rtl/piecewise_linear_table_interp_top.sv
dv/plti_lookup_checker.sv
dv/piecewise_linear_table_interp_top_tb.sv
